// ----- hw/rtl/arpc_pkg.sv -----
// shared constants and types of the arp packet resolver cache
`default_nettype none

package arpc_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  localparam int unsigned TYPE_W     = 16;
  localparam int unsigned IP_W       = 32;
  localparam int unsigned MAC_W      = 48;
  localparam int unsigned ENTRY_W    = IP_W + MAC_W;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned ACTION_W   = 2;

  localparam logic [TYPE_W-1:0] HW_ETHERNET = 16'h0001;
  localparam logic [TYPE_W-1:0] PROTO_IPV4  = 16'h0800;
  localparam logic [TYPE_W-1:0] OP_REQUEST  = 16'h0001;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_IP  = 8'd0,
    CFG_OWN_MAC = 8'd1
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_BAD_HW    = 3'd0,
    STATUS_BAD_PROTO = 3'd1,
    STATUS_NOT_US    = 3'd2,
    STATUS_NO_REPLY  = 3'd3,
    STATUS_REPLY     = 3'd4
  } status_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE     = 2'd0,
    ACT_UPDATED  = 2'd1,
    ACT_INSERTED = 2'd2,
    ACT_FULL     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_INSERT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/arpc_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module arpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/arp_packet_resolver_cache.sv -----
// top level of the arp packet resolver and address cache
`default_nettype none

// Takes one parsed ARP packet per word and returns one result word. A packet
// that is not Ethernet/IPv4 goes from idle straight to the finish state.
// Otherwise the cache is scanned one entry at a time through the single read
// port of the entry RAM, a read state (address) and then a compare state per
// entry, stopping early on a sender match. The input stalls for the whole
// scan; a finished result waits in an output register while the next packet
// is taken. The cache starts empty after reset; own_ip and own_mac reset to
// zero and are written through the config port.
module arp_packet_resolver_cache
  import arpc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write port
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // packet input
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [TYPE_W-1:0]     hw_type_i,
  input  wire logic [TYPE_W-1:0]     proto_type_i,
  input  wire logic [TYPE_W-1:0]     opcode_i,
  input  wire logic [MAC_W-1:0]      sender_mac_i,
  input  wire logic [IP_W-1:0]       sender_ip_i,
  input  wire logic [IP_W-1:0]       target_ip_i,
  // result output
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic [ACTION_W-1:0]        cache_action_o,
  output logic [MAC_W-1:0]           reply_dest_mac_o,
  output logic [IP_W-1:0]            reply_dest_ip_o
);

  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       idx_q;
  logic                   free_found_q;
  logic [IDX_W-1:0]       free_idx_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  action_e                action_q;
  logic [IP_W-1:0]        own_ip_q;
  logic [MAC_W-1:0]       own_mac_q;
  logic                   out_valid_q;

  logic [TYPE_W-1:0]      hw_q, proto_q, op_q;
  logic [MAC_W-1:0]       smac_q;
  logic [IP_W-1:0]        sip_q, tip_q;

  status_e                out_status_q;
  action_e                out_action_q;
  logic [MAC_W-1:0]       out_mac_q;
  logic [IP_W-1:0]        out_ip_q;

  entry_t                 rd_entry;
  entry_t                 wr_entry;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;

  logic                   in_accept;
  logic                   in_ok;
  logic                   hit;
  logic                   last;
  logic                   for_us;
  logic                   out_free;
  status_e                res_status;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_ok     = (hw_type_i == HW_ETHERNET) && (proto_type_i == PROTO_IPV4);
  assign hit       = valid_q[idx_q] && (rd_entry.ip == sip_q);
  assign last      = (idx_q == IDX_W'(TABLE_DEPTH - 1));
  assign for_us    = (tip_q == own_ip_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign wr_entry  = '{ip: sip_q, mac: smac_q};

  arpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .raddr_i (idx_q),
    .rdata_o (rd_entry)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = in_ok ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        priority if (hit) begin
          state_d = ST_FINISH;
        end else if (last) begin
          state_d = for_us ? ST_INSERT : ST_FINISH;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_INSERT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_CMP: begin
        ram_we = hit;
      end
      ST_INSERT: begin
        ram_we    = free_found_q;
        ram_waddr = free_idx_q;
      end
      default: begin
      end
    endcase
  end

  // result status from the latched packet
  always_comb begin
    priority if (hw_q != HW_ETHERNET) begin
      res_status = STATUS_BAD_HW;
    end else if (proto_q != PROTO_IPV4) begin
      res_status = STATUS_BAD_PROTO;
    end else if (!for_us) begin
      res_status = STATUS_NOT_US;
    end else if (op_q == OP_REQUEST) begin
      res_status = STATUS_REPLY;
    end else begin
      res_status = STATUS_NO_REPLY;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      valid_q      <= '0;
      action_q     <= ACT_NONE;
      own_ip_q     <= '0;
      own_mac_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_OWN_IP) begin
          own_ip_q <= cfg_data_i[IP_W-1:0];
        end else if (cfg_index_i == CFG_OWN_MAC) begin
          own_mac_q <= cfg_data_i[MAC_W-1:0];
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            idx_q        <= '0;
            free_found_q <= 1'b0;
            action_q     <= ACT_NONE;
          end
        end
        ST_CMP: begin
          // remember the lowest free slot seen so far
          if (!valid_q[idx_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= idx_q;
          end
          if (hit) begin
            action_q <= ACT_UPDATED;
          end else if (!last) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_INSERT: begin
          if (free_found_q) begin
            valid_q[free_idx_q] <= 1'b1;
            action_q            <= ACT_INSERTED;
          end else begin
            action_q <= ACT_FULL;
          end
        end
        default: begin
        end
      endcase

      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // packet and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hw_q    <= hw_type_i;
      proto_q <= proto_type_i;
      op_q    <= opcode_i;
      smac_q  <= sender_mac_i;
      sip_q   <= sender_ip_i;
      tip_q   <= target_ip_i;
    end
    if (state_q == ST_FINISH && out_free) begin
      out_status_q <= res_status;
      out_action_q <= action_q;
      out_mac_q    <= (res_status == STATUS_REPLY) ? smac_q : '0;
      out_ip_q     <= (res_status == STATUS_REPLY) ? sip_q : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign cache_action_o   = out_action_q;
  assign reply_dest_mac_o = out_mac_q;
  assign reply_dest_ip_o  = out_ip_q;

`ifndef NO_ASSERTIONS
  // the cache never loses an entry
  a_valid_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) >= $past($countones(valid_q)))
    else $error("cache entry lost");

  // entry ram is written only on a refresh or an insert
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CMP || state_q == ST_INSERT))
    else $error("entry ram written outside scan or insert");

  // a dropped packet leaves the cache alone
  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_BAD_HW || status_o == STATUS_BAD_PROTO)
    |-> cache_action_o == ACT_NONE)
    else $error("dropped packet touched the cache");

  // insert or full only when the packet is addressed to us
  a_insert_for_us: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cache_action_o == ACT_INSERTED || cache_action_o == ACT_FULL)
    |-> (status_o == STATUS_NO_REPLY || status_o == STATUS_REPLY))
    else $error("insert on a packet not addressed to us");
`endif

endmodule

`default_nettype wire

// ----- dv/arp_packet_resolver_cache_checker.sv -----
// checker for the arp resolver: predicts each result word from the packets and config it sees
module arp_packet_resolver_cache_checker
  import arpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [TYPE_W-1:0]     hw_type_i,
  input  logic [TYPE_W-1:0]     proto_type_i,
  input  logic [TYPE_W-1:0]     opcode_i,
  input  logic [MAC_W-1:0]      sender_mac_i,
  input  logic [IP_W-1:0]       sender_ip_i,
  input  logic [IP_W-1:0]       target_ip_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [STATUS_W-1:0]   status_i,
  input  logic [ACTION_W-1:0]   cache_action_i,
  input  logic [MAC_W-1:0]      reply_dest_mac_i,
  input  logic [IP_W-1:0]       reply_dest_ip_i,
  output int unsigned           results_o,
  output int unsigned           mismatches_o,
  output int unsigned           inserts_o,
  output int unsigned           table_full_o,
  output int unsigned           replies_o
);

  typedef struct packed {
    status_e          status;
    action_e          action;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } arp_result_t;

  logic [IP_W-1:0]  my_ip;
  logic [MAC_W-1:0] my_mac;
  logic             slot_used [TABLE_DEPTH];
  logic [IP_W-1:0]  slot_ip   [TABLE_DEPTH];
  logic [MAC_W-1:0] slot_mac  [TABLE_DEPTH];

  arp_result_t pending_results [$];

  // updates the cache copy the way the block does and returns the result word
  function automatic arp_result_t resolve_packet(input logic [TYPE_W-1:0] hw,
                                                 input logic [TYPE_W-1:0] proto,
                                                 input logic [TYPE_W-1:0] op,
                                                 input logic [MAC_W-1:0]  smac,
                                                 input logic [IP_W-1:0]   sip,
                                                 input logic [IP_W-1:0]   tip);
    arp_result_t r;
    logic        refreshed;
    int          i;
    r.status = STATUS_BAD_HW;
    r.action = ACT_NONE;
    r.mac    = '0;
    r.ip     = '0;
    refreshed = 1'b0;
    if (hw != HW_ETHERNET) begin
      r.status = STATUS_BAD_HW;
    end else if (proto != PROTO_IPV4) begin
      r.status = STATUS_BAD_PROTO;
    end else begin
      // only the lowest matching slot is refreshed
      for (i = 0; i < TABLE_DEPTH; i++) begin
        if (!refreshed && slot_used[i] && slot_ip[i] == sip) begin
          slot_mac[i] = smac;
          refreshed   = 1'b1;
          r.action    = ACT_UPDATED;
        end
      end
      if (tip != my_ip) begin
        r.status = STATUS_NOT_US;
      end else begin
        if (!refreshed) begin
          r.action = ACT_FULL;
          for (i = 0; i < TABLE_DEPTH; i++) begin
            if (r.action == ACT_FULL && !slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_ip[i]   = sip;
              slot_mac[i]  = smac;
              r.action     = ACT_INSERTED;
            end
          end
        end
        if (op == OP_REQUEST) begin
          r.status = STATUS_REPLY;
          r.mac    = smac;
          r.ip     = sip;
        end else begin
          r.status = STATUS_NO_REPLY;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    arp_result_t want;
    arp_result_t got;
    logic        wrong;
    if (!rst_ni) begin
      my_ip  = '0;
      my_mac = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_used[i] = 1'b0;
        slot_ip[i]   = '0;
        slot_mac[i]  = '0;
      end
      pending_results.delete();
      results_o    <= 0;
      mismatches_o <= 0;
      inserts_o    <= 0;
      table_full_o <= 0;
      replies_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_OWN_IP:  my_ip  = cfg_data_i[IP_W-1:0];
          CFG_OWN_MAC: my_mac = cfg_data_i[MAC_W-1:0];
          default: ;
        endcase
      end
      // results first: a word leaving now never belongs to a packet taken now
      if (out_valid_i && !out_stall_i) begin
        got.status = status_e'(status_i);
        got.action = action_e'(cache_action_i);
        got.mac    = reply_dest_mac_i;
        got.ip     = reply_dest_ip_i;
        results_o <= results_o + 1;
        if (pending_results.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: result word with nothing outstanding: status %0d action %0d",
                     $realtime, status_i, cache_action_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want  = pending_results.pop_front();
          wrong = (got.status !== want.status) || (got.action !== want.action) ||
                  (got.mac !== want.mac) || (got.ip !== want.ip);
          if (wrong) begin
            if (mismatches_o < 10) begin
              $display("%0t: result %0d mismatch", $realtime, results_o);
              $display("  want status %0d action %0d mac %h ip %h",
                       want.status, want.action, want.mac, want.ip);
              $display("  got  status %0d action %0d mac %h ip %h",
                       status_i, cache_action_i, reply_dest_mac_i, reply_dest_ip_i);
            end
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = resolve_packet(hw_type_i, proto_type_i, opcode_i,
                              sender_mac_i, sender_ip_i, target_ip_i);
        pending_results.push_back(want);
        if (want.action == ACT_INSERTED) inserts_o <= inserts_o + 1;
        if (want.action == ACT_FULL) table_full_o <= table_full_o + 1;
        if (want.status == STATUS_REPLY) replies_o <= replies_o + 1;
      end
    end
  end

endmodule

// ----- dv/arp_packet_resolver_cache_test.sv -----
// testbench top for the arp resolver: packet stimulus, config phases and the verdict
module arp_packet_resolver_cache_test
  import arpc_pkg::*;
();

  localparam int unsigned PHASES         = 5;
  localparam int unsigned PHASE_ITEMS    = 340;
  localparam int unsigned POOL_SIZE      = 40;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned PRESSURE_PHASE = 2;
  localparam int unsigned SETTLE_CYCLES  = 2 * TABLE_DEPTH + 8;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;
  localparam logic [TYPE_W-1:0]    OP_REPLY     = 16'h0002;
  localparam logic [TYPE_W-1:0]    PROTO_IPV6   = 16'h86DD;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [TYPE_W-1:0]     hw_type;
  logic [TYPE_W-1:0]     proto_type;
  logic [TYPE_W-1:0]     opcode;
  logic [MAC_W-1:0]      sender_mac;
  logic [IP_W-1:0]       sender_ip;
  logic [IP_W-1:0]       target_ip;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   status;
  logic [ACTION_W-1:0]   cache_action;
  logic [MAC_W-1:0]      reply_dest_mac;
  logic [IP_W-1:0]       reply_dest_ip;

  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned inserts;
  int unsigned table_full;
  int unsigned replies;

  int unsigned     packets_sent;
  int unsigned     burst_left;
  logic            sink_hold;
  logic [IP_W-1:0] cur_ip;
  logic [IP_W-1:0] ip_pool [POOL_SIZE];

  arp_packet_resolver_cache dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .hw_type_i        (hw_type),
    .proto_type_i     (proto_type),
    .opcode_i         (opcode),
    .sender_mac_i     (sender_mac),
    .sender_ip_i      (sender_ip),
    .target_ip_i      (target_ip),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .cache_action_o   (cache_action),
    .reply_dest_mac_o (reply_dest_mac),
    .reply_dest_ip_o  (reply_dest_ip)
  );

  arp_packet_resolver_cache_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .hw_type_i        (hw_type),
    .proto_type_i     (proto_type),
    .opcode_i         (opcode),
    .sender_mac_i     (sender_mac),
    .sender_ip_i      (sender_ip),
    .target_ip_i      (target_ip),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .cache_action_i   (cache_action),
    .reply_dest_mac_i (reply_dest_mac),
    .reply_dest_ip_i  (reply_dest_ip),
    .results_o        (results_seen),
    .mismatches_o     (mismatches),
    .inserts_o        (inserts),
    .table_full_o     (table_full),
    .replies_o        (replies)
  );

  always #10 clk = ~clk;

  // holds the packet until taken, then keeps the burst going or, at the end of a burst, sometimes idles a while
  task automatic offer_packet(input logic [TYPE_W-1:0] hw, input logic [TYPE_W-1:0] proto,
                              input logic [TYPE_W-1:0] op, input logic [MAC_W-1:0] smac,
                              input logic [IP_W-1:0] sip, input logic [IP_W-1:0] tip);
    int unsigned gap;
    in_valid   <= 1'b1;
    hw_type    <= hw;
    proto_type <= proto;
    opcode     <= op;
    sender_mac <= smac;
    sender_ip  <= sip;
    target_ip  <= tip;
    do @(posedge clk); while (in_stall);
    packets_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // mostly well-formed packets around a pool of known senders, some noise
  task automatic random_packet();
    logic [TYPE_W-1:0] hw;
    logic [TYPE_W-1:0] proto;
    logic [TYPE_W-1:0] op;
    logic [MAC_W-1:0]  smac;
    logic [IP_W-1:0]   sip;
    logic [IP_W-1:0]   tip;
    int unsigned       pick;
    pick  = $urandom_range(0, 99);
    hw    = HW_ETHERNET;
    proto = PROTO_IPV4;
    smac  = {16'($urandom()), 32'($urandom())};
    if (pick < 6) begin
      hw    = 16'($urandom());
      proto = 16'($urandom());
    end else if (pick < 12) begin
      proto = 16'($urandom());
    end
    pick = $urandom_range(0, 19);
    if (pick < 12) op = OP_REQUEST;
    else if (pick < 17) op = OP_REPLY;
    else op = 16'($urandom());
    sip  = ($urandom_range(0, 4) == 0) ? $urandom() : ip_pool[$urandom_range(0, POOL_SIZE-1)];
    pick = $urandom_range(0, 9);
    if (pick < 6) tip = cur_ip;
    else if (pick < 8) tip = ip_pool[$urandom_range(0, POOL_SIZE-1)];
    else tip = $urandom();
    offer_packet(hw, proto, op, smac, sip, tip);
  endtask

  // config writes back to back; valid drops only after the last one
  task automatic program_address(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
                                 input logic poke_unmapped);
    cur_ip    = ip;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_OWN_IP;
    cfg_data  <= {16'($urandom()), ip};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_OWN_MAC;
    cfg_data  <= mac;
    do @(posedge clk); while (!cfg_ready);
    if (poke_unmapped) begin
      cfg_index <= CFG_UNMAPPED;
      cfg_data  <= {16'($urandom()), 32'($urandom())};
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_seen < packets_sent) @(posedge clk);
  endtask

  // receiver: runs of random stall patterns, plus one long hold-off when asked
  initial begin : result_sink
    int unsigned mode;
    int unsigned span;
    logic        held;
    out_stall = 1'b0;
    held      = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(1, 60);
      for (int k = 0; k < span; k++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= (k % 2 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    hw_type      = '0;
    proto_type   = '0;
    opcode       = '0;
    sender_mac   = '0;
    sender_ip    = '0;
    target_ip    = '0;
    sink_hold    = 1'b0;
    packets_sent = 0;
    burst_left   = 0;
    cur_ip       = '0;
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin ip = '0; mac = '0; end
        1: begin ip = '1; mac = '1; end
        3: begin
          ip  = ip_pool[$urandom_range(2, POOL_SIZE-1)];
          mac = {16'($urandom()), 32'($urandom())};
        end
        default: begin
          ip  = $urandom();
          mac = {16'($urandom()), 32'($urandom())};
        end
      endcase
      program_address(ip, mac, phase == 1);

      if (phase == 0) begin
        // dropped packets: bad hardware type, then bad protocol
        offer_packet(16'h0000, PROTO_IPV4, OP_REQUEST, 48'h0123_4567_89ab, ip_pool[2], cur_ip);
        offer_packet('1, '1, '1, '1, '1, cur_ip);
        offer_packet(HW_ETHERNET, 16'h0000, OP_REQUEST, '0, '0, cur_ip);
        offer_packet(HW_ETHERNET, '1, OP_REQUEST, '1, ip_pool[2], '1);
        offer_packet(HW_ETHERNET, PROTO_IPV6, OP_REQUEST, 48'haaaa_5555_aaaa, ip_pool[2], cur_ip);
        // not for us with an empty cache
        offer_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'h5555_aaaa_5555, ip_pool[2], 32'h1);
        // request to us inserts and replies, later words refresh the entry
        offer_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'h0a0b_0c0d_0e0f, ip_pool[2], cur_ip);
        offer_packet(HW_ETHERNET, PROTO_IPV4, OP_REPLY, 48'hf0e0_d0c0_b0a0, ip_pool[2], cur_ip);
        offer_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'h1111_2222_3333, ip_pool[2], '1);
        // unsupported opcodes and address extremes
        offer_packet(HW_ETHERNET, PROTO_IPV4, 16'h0000, '0, '0, cur_ip);
        offer_packet(HW_ETHERNET, PROTO_IPV4, '1, '1, '1, cur_ip);
        offer_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'h8000_0000_0001, '1, cur_ip);
        offer_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'h7fff_ffff_fffe, $urandom(), '1);
        offer_packet(HW_ETHERNET, PROTO_IPV4, 16'h0003, '0, ip_pool[3], cur_ip);
      end

      if (phase == PRESSURE_PHASE) sink_hold <= 1'b1;
      repeat (PHASE_ITEMS) random_packet();
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d packets over %0d address settings with a long output hold-off",
             packets_sent, PHASES);
    $display("cache inserts %0d, table-full %0d, replies %0d, result words %0d, mismatches %0d",
             inserts, table_full, replies, results_seen, mismatches);
    if (mismatches == 0 && results_seen == packets_sent) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
